// ----- sv/shoreline_flow_floodfill_core_macros.svh -----
// Assertion macros for the shoreline flow fill core checker.
// Used by the checker file only; expects clk and rst in scope.
`ifndef SHORELINE_FLOW_FLOODFILL_CORE_MACROS_SVH
`define SHORELINE_FLOW_FLOODFILL_CORE_MACROS_SVH

// Same-cycle implication, off during reset
`define SFFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define SFFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Holds in the cycle after reset
`define SFFC_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- sv/sffc_pkg.sv -----
// Shared constants, codes, types and neighbor helpers of the shoreline flow fill core.
// No dependencies.
`default_nettype none

package sffc_pkg;

  localparam int GRID_BITS    = 6;
  localparam int GRID_SIZE    = 1 << GRID_BITS;
  localparam int PIX_BITS     = 2 * GRID_BITS;
  localparam int QUEUE_BITS   = 8;
  localparam int QUEUE_PIXELS = 1 << QUEUE_BITS;

  localparam int HEIGHT_W = 16;
  localparam int WORD_W   = 16;
  localparam int COMP_W   = 11;
  localparam int LEN2_W   = 20;
  localparam int DIR_W    = 8;
  localparam int QUO_W    = 14;
  localparam int PROD_W   = LEN2_W + QUO_W - 1;
  localparam int SCALE_K  = 127 * 127;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = QUO_W / 2;

  localparam logic [WORD_W-1:0] FLOW_ZERO = 16'h8080;

  typedef logic [1:0] op_t;
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_FILL  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  typedef logic [1:0] tag_t;
  localparam tag_t TAG_WATER  = 2'd0;
  localparam tag_t TAG_QUEUED = 2'd1;
  localparam tag_t TAG_GROUND = 2'd2;
  localparam tag_t TAG_DONE   = 2'd3;

  typedef logic [2:0] nb_t;
  localparam nb_t NB_CENTER = 3'd0;
  localparam nb_t NB_LEFT   = 3'd1;
  localparam nb_t NB_RIGHT  = 3'd2;
  localparam nb_t NB_UP     = 3'd3;
  localparam nb_t NB_DOWN   = 3'd4;
  localparam nb_t NB_COMMIT = 3'd5;

  localparam logic [PIX_BITS-1:0]  ROW_STEP = PIX_BITS'(GRID_SIZE);
  localparam logic [GRID_BITS-1:0] EDGE_HI  = GRID_BITS'(GRID_SIZE - 1);

  typedef struct packed {
    logic                     start;
    logic signed [COMP_W-1:0] comp;
    logic [LEN2_W-1:0]        len2;
  } scale_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIR_W-1:0] value;
  } scale_rsp_t;

  function automatic logic nb_exists(logic [PIX_BITS-1:0] p, nb_t j);
    logic [GRID_BITS-1:0] col;
    logic [GRID_BITS-1:0] row;
    logic                 ok;
    col = p[GRID_BITS-1:0];
    row = p[PIX_BITS-1:GRID_BITS];
    unique case (j)
      NB_LEFT:  ok = (col != '0);
      NB_RIGHT: ok = (col != EDGE_HI);
      NB_UP:    ok = (row != '0);
      NB_DOWN:  ok = (row != EDGE_HI);
      default:  ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic [PIX_BITS-1:0] nb_addr(logic [PIX_BITS-1:0] p, nb_t j);
    logic [PIX_BITS-1:0] a;
    unique case (j)
      NB_LEFT:  a = p - 1'b1;
      NB_RIGHT: a = p + 1'b1;
      NB_UP:    a = p - ROW_STEP;
      NB_DOWN:  a = p + ROW_STEP;
      default:  a = p;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sffc_scale.sv -----
// Shared scaling unit: c*127/|(X,Y)| truncated toward zero, by multiply,
// restoring division and bitwise square root. Uses sffc_pkg.
`default_nettype none

module sffc_scale (
  input  wire                 clk,
  input  wire                 rst,
  input  sffc_pkg::scale_req_t req,
  output sffc_pkg::scale_rsp_t rsp
);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_MUL, S_DIV, S_SQRT, S_DONE} state_t;

  state_t                          state;
  logic                            neg;
  logic [sffc_pkg::COMP_W-2:0]     mag;
  logic [sffc_pkg::LEN2_W-1:0]     len2;
  logic [sffc_pkg::LEN2_W-1:0]     mm;
  logic [sffc_pkg::LEN2_W-1:0]     rem;
  logic [sffc_pkg::QUO_W-1:0]      dlo;
  logic [sffc_pkg::QUO_W-1:0]      quo;
  logic [sffc_pkg::QUO_W-1:0]      acc;
  logic [sffc_pkg::QUO_W:0]        root;
  logic [sffc_pkg::QUO_W-1:0]      bitv;
  logic [3:0]                      cnt;

  logic signed [sffc_pkg::COMP_W-1:0] abs_c;
  logic [sffc_pkg::PROD_W-1:0]     prod;
  logic [sffc_pkg::LEN2_W:0]       trial;
  logic                            div_ge;
  logic [sffc_pkg::QUO_W:0]        root_bit;
  logic                            sqrt_ge;

  always_comb begin
    abs_c    = req.comp[sffc_pkg::COMP_W-1] ? -req.comp : req.comp;
    prod     = sffc_pkg::PROD_W'(mm) * sffc_pkg::PROD_W'(sffc_pkg::SCALE_K);
    trial    = {rem, dlo[sffc_pkg::QUO_W-1]};
    div_ge   = trial >= {1'b0, len2};
    root_bit = root + (sffc_pkg::QUO_W+1)'(bitv);
    sqrt_ge  = {1'b0, acc} >= root_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.done  <= 1'b0;
    end else begin
      rsp.done <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            neg   <= req.comp[sffc_pkg::COMP_W-1];
            mag   <= abs_c[sffc_pkg::COMP_W-2:0];
            len2  <= req.len2;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          mm    <= sffc_pkg::LEN2_W'(mag) * sffc_pkg::LEN2_W'(mag);
          state <= S_MUL;
        end
        S_MUL: begin
          rem   <= sffc_pkg::LEN2_W'(prod[sffc_pkg::PROD_W-1:sffc_pkg::QUO_W]);
          dlo   <= prod[sffc_pkg::QUO_W-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= div_ge ? sffc_pkg::LEN2_W'(trial - {1'b0, len2})
                        : trial[sffc_pkg::LEN2_W-1:0];
          quo <= {quo[sffc_pkg::QUO_W-2:0], div_ge};
          dlo <= dlo << 1;
          if (cnt == 4'(sffc_pkg::DIV_STEPS - 1)) begin
            acc   <= {quo[sffc_pkg::QUO_W-2:0], div_ge};
            root  <= '0;
            bitv  <= sffc_pkg::QUO_W'(1) << (sffc_pkg::QUO_W - 2);
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (sqrt_ge) begin
            acc  <= acc - root_bit[sffc_pkg::QUO_W-1:0];
            root <= (root >> 1) + (sffc_pkg::QUO_W+1)'(bitv);
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 4'(sffc_pkg::SQRT_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          rsp.value <= neg ? -$signed(root[sffc_pkg::DIR_W-1:0])
                           : $signed(root[sffc_pkg::DIR_W-1:0]);
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/shoreline_flow_floodfill_core.sv -----
// Shoreline flow fill core: height and flow stores, tag store, ring queue, fill
// sequencer and response register. Uses sffc_pkg and sffc_scale.
//
// A height write and a read both end when the response register takes the result.
// A fill classifies each pixel (one height read per cycle through the single read
// port), then scans the tag store, walks the queued pixels and sweeps leftovers;
// for a walked pixel of nonzero flow length the shared scaling unit (multiply,
// 14-step division, 7-step root) runs once per component. The block takes no
// command until the current one has produced its response.
`default_nettype none

module shoreline_flow_floodfill_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wen,
  input  wire  [15:0] cfg_wdata,
  input  wire         cmd_valid,
  output logic        cmd_stall,
  input  wire  [1:0]  op,
  input  wire  [11:0] address,
  input  wire  [15:0] height,
  output logic        rsp_valid,
  input  wire         rsp_stall,
  output logic [15:0] flow_word,
  output logic [1:0]  op_done
);

  localparam int PB = sffc_pkg::PIX_BITS;
  localparam int QB = sffc_pkg::QUEUE_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_RESP, ST_CLS, ST_SCAN_RD, ST_SCAN_CHK, ST_POP, ST_POP_WAIT,
    ST_NB_RD, ST_NB_CHK, ST_CALC, ST_LENX, ST_LENY, ST_SCX_GO, ST_SCX_WAIT,
    ST_SCY_GO, ST_SCY_WAIT, ST_STORE, ST_FIN_RD, ST_FIN_CHK
  } state_t;

  state_t state;

  logic [15:0]             water_level;
  logic [15:0]             res_word;
  sffc_pkg::op_t           res_op;

  logic [15:0]             height_mem [1 << PB];
  logic [15:0]             flow_mem   [1 << PB];
  sffc_pkg::tag_t          tag_mem    [1 << PB];
  logic [PB-1:0]           queue_mem  [1 << QB];

  logic [15:0]             hrd;
  logic [15:0]             frd;
  sffc_pkg::tag_t          trd;
  logic [PB-1:0]           qrd;

  logic [PB-1:0]           pix;
  logic [PB-1:0]           scan_index;
  logic [PB-1:0]           cur;
  sffc_pkg::nb_t           nb;
  logic                    wet;
  logic [QB-1:0]           queue_head;
  logic [QB-1:0]           queue_tail;
  logic [QB:0]             queue_count;

  logic signed [2:0]       fx;
  logic signed [2:0]       fy;
  logic signed [9:0]       nx;
  logic signed [9:0]       ny;
  logic signed [sffc_pkg::COMP_W-1:0] vx;
  logic signed [sffc_pkg::COMP_W-1:0] vy;
  logic [sffc_pkg::LEN2_W-1:0]        len2;
  logic signed [sffc_pkg::DIR_W-1:0]  sx;
  logic signed [sffc_pkg::DIR_W-1:0]  sy;

  sffc_pkg::scale_req_t    sreq;
  sffc_pkg::scale_rsp_t    srsp;

  logic                    accept;
  logic                    rsp_free;
  logic                    cls_hit;
  logic                    wet_next;
  logic [PB-1:0]           nb_q;
  logic                    nb_ok;
  logic                    q_full;
  logic                    push_scan;
  logic                    push_nb;
  logic                    hra_sel;
  logic [PB-1:0]           hra;
  logic [PB-1:0]           fra;
  logic [PB-1:0]           tra;
  logic                    twe;
  logic [PB-1:0]           twa;
  sffc_pkg::tag_t          twd;
  logic                    fwe;
  logic [PB-1:0]           fwa;
  logic [15:0]             fwd;
  logic                    qwe;
  logic [PB-1:0]           qwd;
  logic signed [sffc_pkg::COMP_W-1:0] fx_e;
  logic signed [sffc_pkg::COMP_W-1:0] fy_e;
  logic signed [sffc_pkg::COMP_W-1:0] sq_in;
  logic signed [2*sffc_pkg::COMP_W-1:0] sq_full;
  logic [sffc_pkg::LEN2_W-1:0]        len2_sum;
  logic signed [7:0]       bx;
  logic signed [7:0]       by;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid & ~cmd_stall;
  assign rsp_free  = ~rsp_valid | ~rsp_stall;

  always_comb begin
    cls_hit  = 1'b0;
    if (nb == sffc_pkg::NB_LEFT) begin
      cls_hit = hrd < water_level;
    end else if (nb != sffc_pkg::NB_CENTER) begin
      cls_hit = sffc_pkg::nb_exists(pix, sffc_pkg::nb_t'(nb - 1'b1)) &&
                (hrd != '0) && (hrd < water_level);
    end
    wet_next = wet | cls_hit;

    nb_q   = sffc_pkg::nb_addr(cur, nb);
    nb_ok  = sffc_pkg::nb_exists(cur, nb);
    q_full = (queue_count == (QB+1)'(sffc_pkg::QUEUE_PIXELS));
    push_scan = (state == ST_SCAN_CHK) && (trd == sffc_pkg::TAG_WATER);
    push_nb   = (state == ST_NB_CHK) && (trd == sffc_pkg::TAG_WATER) && !q_full;

    hra_sel = (state == ST_CLS) && (nb != sffc_pkg::NB_COMMIT);
    hra     = hra_sel ? sffc_pkg::nb_addr(pix, nb) : pix;

    fra = address;
    tra = pix;
    case (state)
      ST_NB_RD:   begin fra = nb_q; tra = nb_q; end
      ST_SCAN_RD: tra = scan_index;
      default: ;
    endcase

    twe = 1'b0;
    twa = pix;
    twd = sffc_pkg::TAG_GROUND;
    fwe = 1'b0;
    fwa = pix;
    fwd = sffc_pkg::FLOW_ZERO;
    qwe = push_scan | push_nb;
    qwd = push_scan ? scan_index : nb_q;
    case (state)
      ST_CLS: begin
        twe = (nb == sffc_pkg::NB_COMMIT);
        twd = wet_next ? sffc_pkg::TAG_WATER : sffc_pkg::TAG_GROUND;
      end
      ST_SCAN_CHK: begin
        twe = push_scan;
        twa = scan_index;
        twd = sffc_pkg::TAG_QUEUED;
      end
      ST_NB_CHK: begin
        twe = push_nb;
        twa = nb_q;
        twd = sffc_pkg::TAG_QUEUED;
      end
      ST_STORE: begin
        twe = 1'b1;
        twa = cur;
        twd = sffc_pkg::TAG_DONE;
        fwe = 1'b1;
        fwa = cur;
        fwd = {sy + 8'sh80, sx + 8'sh80};
      end
      ST_FIN_CHK: begin
        fwe = (trd != sffc_pkg::TAG_DONE);
      end
      default: ;
    endcase

    fx_e     = sffc_pkg::COMP_W'(fx);
    fy_e     = sffc_pkg::COMP_W'(fy);
    sq_in    = (state == ST_LENX) ? vx : vy;
    sq_full  = sq_in * sq_in;
    len2_sum = len2 + sq_full[sffc_pkg::LEN2_W-1:0];
    bx       = $signed({~frd[7], frd[6:0]});
    by       = $signed({~frd[15], frd[14:8]});

    sreq.start = (state == ST_SCX_GO) || (state == ST_SCY_GO);
    sreq.comp  = (state == ST_SCX_GO) ? vx : vy;
    sreq.len2  = len2;
  end

  sffc_scale u_scale (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  always_ff @(posedge clk) begin
    if (accept && op == sffc_pkg::OP_WRITE) begin
      height_mem[address] <= height;
    end
    hrd <= height_mem[hra];
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      flow_mem[fwa] <= fwd;
    end
    frd <= flow_mem[fra];
  end

  always_ff @(posedge clk) begin
    if (twe) begin
      tag_mem[twa] <= twd;
    end
    trd <= tag_mem[tra];
  end

  always_ff @(posedge clk) begin
    if (qwe) begin
      queue_mem[queue_tail] <= qwd;
    end
    qrd <= queue_mem[queue_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      water_level <= '0;
    end else if (cfg_wen) begin
      water_level <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid   <= 1'b0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      scan_index  <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && state != ST_RESP) begin
        rsp_valid <= 1'b0;
      end
      if (qwe) begin
        queue_tail <= queue_tail + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_op   <= op;
            res_word <= '0;
            unique case (op)
              sffc_pkg::OP_READ: state <= ST_READ;
              sffc_pkg::OP_FILL: begin
                pix         <= '0;
                nb          <= sffc_pkg::NB_CENTER;
                wet         <= 1'b0;
                queue_head  <= '0;
                queue_tail  <= '0;
                queue_count <= '0;
                scan_index  <= '0;
                state       <= ST_CLS;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_READ: begin
          res_word <= frd;
          state    <= ST_RESP;
        end
        ST_RESP: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            flow_word <= res_word;
            op_done   <= res_op;
            state     <= ST_IDLE;
          end
        end
        ST_CLS: begin
          if (nb == sffc_pkg::NB_COMMIT) begin
            wet <= 1'b0;
            nb  <= sffc_pkg::NB_CENTER;
            pix <= pix + 1'b1;
            if (pix == '1) begin
              scan_index <= '0;
              state      <= ST_SCAN_RD;
            end
          end else begin
            wet <= wet_next;
            nb  <= nb + 1'b1;
          end
        end
        ST_SCAN_RD: state <= ST_SCAN_CHK;
        ST_SCAN_CHK: begin
          if (push_scan) begin
            queue_count <= queue_count + 1'b1;
            state       <= ST_POP;
          end else if (scan_index == '1) begin
            scan_index <= '0;
            pix        <= '0;
            state      <= ST_FIN_RD;
          end else begin
            scan_index <= scan_index + 1'b1;
            state      <= ST_SCAN_RD;
          end
        end
        ST_POP: begin
          if (queue_count != '0) begin
            queue_head  <= queue_head + 1'b1;
            queue_count <= queue_count - 1'b1;
            state       <= ST_POP_WAIT;
          end else if (scan_index == '1) begin
            scan_index <= '0;
            pix        <= '0;
            state      <= ST_FIN_RD;
          end else begin
            scan_index <= scan_index + 1'b1;
            state      <= ST_SCAN_RD;
          end
        end
        ST_POP_WAIT: begin
          cur   <= qrd;
          nb    <= sffc_pkg::NB_LEFT;
          fx    <= '0;
          fy    <= '0;
          nx    <= '0;
          ny    <= '0;
          state <= ST_NB_RD;
        end
        ST_NB_RD: begin
          if (nb_ok) begin
            state <= ST_NB_CHK;
          end else if (nb == sffc_pkg::NB_DOWN) begin
            state <= ST_CALC;
          end else begin
            nb <= nb + 1'b1;
          end
        end
        ST_NB_CHK: begin
          if (push_nb) begin
            queue_count <= queue_count + 1'b1;
          end
          if (trd == sffc_pkg::TAG_DONE) begin
            nx <= nx + 10'(bx);
            ny <= ny + 10'(by);
            unique case (nb)
              sffc_pkg::NB_LEFT:  fx <= fx + 3'sd1;
              sffc_pkg::NB_RIGHT: fx <= fx - 3'sd1;
              sffc_pkg::NB_UP:    fy <= fy + 3'sd1;
              default:            fy <= fy - 3'sd1;
            endcase
          end
          if (nb == sffc_pkg::NB_DOWN) begin
            state <= ST_CALC;
          end else begin
            nb    <= nb + 1'b1;
            state <= ST_NB_RD;
          end
        end
        ST_CALC: begin
          vx    <= (fx_e <<< 2) + (fx_e <<< 1) + sffc_pkg::COMP_W'(nx);
          vy    <= (fy_e <<< 2) + (fy_e <<< 1) + sffc_pkg::COMP_W'(ny);
          len2  <= '0;
          state <= ST_LENX;
        end
        ST_LENX: begin
          len2  <= len2_sum;
          state <= ST_LENY;
        end
        ST_LENY: begin
          len2 <= len2_sum;
          if (len2_sum == '0) begin
            sx    <= '0;
            sy    <= '0;
            state <= ST_STORE;
          end else begin
            state <= ST_SCX_GO;
          end
        end
        ST_SCX_GO: state <= ST_SCX_WAIT;
        ST_SCX_WAIT: begin
          if (srsp.done) begin
            sx    <= srsp.value;
            state <= ST_SCY_GO;
          end
        end
        ST_SCY_GO: state <= ST_SCY_WAIT;
        ST_SCY_WAIT: begin
          if (srsp.done) begin
            sy    <= srsp.value;
            state <= ST_STORE;
          end
        end
        ST_STORE: state <= ST_POP;
        ST_FIN_RD: state <= ST_FIN_CHK;
        ST_FIN_CHK: begin
          pix <= pix + 1'b1;
          if (pix == '1) begin
            state <= ST_RESP;
          end else begin
            state <= ST_FIN_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/sffc_checker.sv -----
// Port-level checker for the shoreline flow fill core, bound to the top level.
// Depends on shoreline_flow_floodfill_core_macros.svh and sffc_pkg.
`default_nettype none
`include "shoreline_flow_floodfill_core_macros.svh"

module sffc_checker (
  input wire        clk,
  input wire        rst,
  input wire        cmd_valid,
  input wire        cmd_stall,
  input wire        rsp_valid,
  input wire        rsp_stall,
  input wire [15:0] flow_word,
  input wire [1:0]  op_done
);

  `SFFC_ASSERT_RESET(a_rsp_idle_after_reset, !rsp_valid, "response valid after reset")
  `SFFC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(flow_word) && $stable(op_done), "stalled response changed")
  `SFFC_ASSERT_SAME(a_word_zero, rsp_valid && op_done != sffc_pkg::OP_READ, flow_word == 16'd0, "nonzero word on non-read response")
  `SFFC_ASSERT_NEXT(a_one_at_a_time, cmd_valid && !cmd_stall, cmd_stall, "second transfer taken while busy")

endmodule

bind shoreline_flow_floodfill_core sffc_checker u_sffc_checker (.*);

`default_nettype wire
